[design/mrcm_pkg.sv]
package mrcm_pkg;

   // Fixed field widths
   localparam int SampleWidth = 32;
   localparam int LengthWidth = 13;
   localparam int IndexWidth  = 12;
   localparam int SumWidth    = 44;
   localparam int RowPosWidth = 12;
   localparam int ColPosWidth = 10;
   localparam int CsrIdxWidth = 4;
   localparam int CsrDataWidth = 13;
   localparam int RowsRegWidth = 13;
   localparam int ColsRegWidth = 11;

   // Divider runs one quotient bit per cycle over the whole sum
   localparam int DivSteps     = SumWidth;
   localparam int DivCntWidth  = 6;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_COLUMN_MODE = 4'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_USE_LENGTHS = 4'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_NUM_ROWS    = 4'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_NUM_COLS    = 4'd3;

   typedef struct packed {
      logic signed [SampleWidth-1:0] sample;
      logic [LengthWidth-1:0]        seg_length;
   } req_payload_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] mean;
      logic [IndexWidth-1:0]         out_index;
      logic                          zero_length;
      logic                          last;
   } rsp_payload_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic update;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic emit;
      logic div_done;
   } status_type;

endpackage

[design/masked_row_column_mean.sv]
// Masked row/column mean over a streamed matrix.
// Input channel req_*: one matrix element per beat, row-major, with the
// length that applies to its row (row mode) or column (column mode).
// Result channel rsp_*: one mean per row, or per column during the last
// row, with its index, a zero-length flag and a last-of-matrix flag.
// Configuration channel csr_*: always ready; write only while idle.
// Timing: one beat at a time. A beat that closes no mean passes through
// accept, column store read and update before the next can be taken. A
// beat that closes a mean then runs the bit-serial divider (a quotient
// step for each bit of the sum, then a finishing step) and loads the
// output register. req_ready stays low while a beat is in progress.
// The result sits in an output register; a stalled receiver holds it, and
// a following mean waits after its division until that register frees.
// After reset the column store is cleared one entry a cycle with req_ready
// low; configuration writes are taken meanwhile.
module masked_row_column_mean #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  mrcm_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output mrcm_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mrcm_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [mrcm_pkg::CsrDataWidth-1:0] csr_data
);
   import mrcm_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mrcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mrcm_dpath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

[design/mrcm_ctrl.sv]
module mrcm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mrcm_pkg::cmd_type    cmd,
   input  mrcm_pkg::status_type status
);
   import mrcm_pkg::*;

   typedef enum logic [2:0] {
      CLEAR, IDLE, READ, UPDATE, DIVIDE, HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Decode commands and next state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = IDLE;
         end
         IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = READ;
            end
         end
         READ: state_in = UPDATE;
         UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? DIVIDE : IDLE;
         end
         DIVIDE: begin
            if (status.div_done) state_in = HOLD;
            else cmd.div_step = 1'b1;
         end
         HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // Hold state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/mrcm_dpath.sv]
module mrcm_dpath #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mrcm_pkg::req_payload_type            req_payload,
   output mrcm_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_valid,
   input  logic [mrcm_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [mrcm_pkg::CsrDataWidth-1:0]    csr_data,
   input  mrcm_pkg::cmd_type                    cmd,
   output mrcm_pkg::status_type                 status
);
   import mrcm_pkg::*;

   localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW  = $clog2(MAX_ROWS + 1);
   localparam int CW  = $clog2(MAX_COLS + 1);
   localparam int XW0 = (RW > CW) ? RW : CW;
   localparam int XW  = (XW0 > LengthWidth) ? XW0 : LengthWidth;
   localparam int MW  = LengthWidth + SumWidth;

   // Configuration registers
   logic                    column_mode_ff, use_lengths_ff;
   logic [RowsRegWidth-1:0] num_rows_ff;
   logic [ColsRegWidth-1:0] num_cols_ff;

   // Stream position and row accumulator
   logic [RowPosWidth-1:0]     row_pos_ff;
   logic [ColPosWidth-1:0]     col_pos_ff;
   logic signed [SumWidth-1:0] row_sum_ff;

   // Item held through the read
   logic signed [SampleWidth-1:0] x_ff;
   logic [LengthWidth-1:0]        seg_ff;

   // Column store: length over sum
   logic [MW-1:0] mem [MAX_COLS];
   logic [MW-1:0] rd_ff;
   logic [AW-1:0] clr_ff;

   // Divider
   logic [SumWidth-1:0]    quo_ff;
   logic [XW-1:0]          rem_ff;
   logic [XW-1:0]          dlen_ff;
   logic [DivCntWidth-1:0] cnt_ff;
   logic                   neg_ff, zero_ff, last_ff;
   logic [IndexWidth-1:0]  idx_ff;
   logic [XW:0]            trial;
   logic                   qbit;

   rsp_payload_type rsp_ff;

   logic [XW-1:0]              rows_eff, cols_eff, len, lraw_x;
   logic [LengthWidth-1:0]     lraw;
   logic [AW-1:0]              caddr;
   logic                       end_row, end_mat, counted;
   logic signed [SumWidth-1:0] base, sum_new, xe, mag_src;
   logic [SumWidth-1:0]        mag;
   logic [SampleWidth-1:0]     qlow;

   assign rsp_payload = rsp_ff;

   // Clamp sizes to their legal extent
   always_comb begin
      if (num_rows_ff == '0) rows_eff = XW'(1);
      else if (XW'(num_rows_ff) > XW'(MAX_ROWS)) rows_eff = XW'(MAX_ROWS);
      else rows_eff = XW'(num_rows_ff);
      if (num_cols_ff == '0) cols_eff = XW'(1);
      else if (XW'(num_cols_ff) > XW'(MAX_COLS)) cols_eff = XW'(MAX_COLS);
      else cols_eff = XW'(num_cols_ff);
   end

   assign end_row = ((XW+1)'(col_pos_ff) + (XW+1)'(1)) >= (XW+1)'(cols_eff);
   assign end_mat = ((XW+1)'(row_pos_ff) + (XW+1)'(1)) >= (XW+1)'(rows_eff);
   assign caddr   = (32'(col_pos_ff) < MAX_COLS) ? AW'(col_pos_ff) : AW'(MAX_COLS - 1);
   assign xe      = SumWidth'(x_ff);

   // Pick length, base and new sum for the current mode
   always_comb begin
      if (column_mode_ff) begin
         lraw = (row_pos_ff == '0) ? seg_ff : rd_ff[MW-1:SumWidth];
         base = (row_pos_ff == '0) ? '0 : $signed(rd_ff[SumWidth-1:0]);
      end else begin
         lraw = seg_ff;
         base = (col_pos_ff == '0) ? '0 : row_sum_ff;
      end
      lraw_x = XW'(lraw);
      if (column_mode_ff) begin
         if (!use_lengths_ff) len = rows_eff;
         else len = (lraw_x > rows_eff) ? rows_eff : lraw_x;
         counted = XW'(row_pos_ff) < len;
      end else begin
         if (!use_lengths_ff) len = cols_eff;
         else len = (lraw_x > cols_eff) ? cols_eff : lraw_x;
         counted = XW'(col_pos_ff) < len;
      end
      sum_new = base + (counted ? xe : '0);
      mag_src = sum_new[SumWidth-1] ? -sum_new : sum_new;
      mag     = mag_src;
   end

   assign status.emit       = column_mode_ff ? end_mat : end_row;
   assign status.div_done   = (cnt_ff == '0);
   assign status.clear_done = (clr_ff == AW'(MAX_COLS - 1));

   // One restoring step
   assign trial = {rem_ff, quo_ff[SumWidth-1]};
   assign qbit  = trial >= (XW+1)'(dlen_ff);
   assign qlow  = quo_ff[SampleWidth-1:0];

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         column_mode_ff <= 1'b0;
         use_lengths_ff <= 1'b0;
         num_rows_ff    <= RowsRegWidth'(1);
         num_cols_ff    <= ColsRegWidth'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COLUMN_MODE: column_mode_ff <= csr_data[0];
            CSR_USE_LENGTHS: use_lengths_ff <= csr_data[0];
            CSR_NUM_ROWS:    num_rows_ff    <= csr_data[RowsRegWidth-1:0];
            CSR_NUM_COLS:    num_cols_ff    <= csr_data[ColsRegWidth-1:0];
            default: ;
         endcase
      end
   end

   // Advance positions and the row accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
         row_sum_ff <= '0;
         clr_ff     <= '0;
         cnt_ff     <= '0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + AW'(1);
         if (cmd.update) begin
            if (!column_mode_ff) row_sum_ff <= end_row ? '0 : sum_new;
            if (end_row) begin
               col_pos_ff <= '0;
               row_pos_ff <= end_mat ? '0 : row_pos_ff + RowPosWidth'(1);
            end else begin
               col_pos_ff <= col_pos_ff + ColPosWidth'(1);
            end
            if (status.emit) cnt_ff <= DivCntWidth'(DivSteps);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - DivCntWidth'(1);
         end
      end
   end

   // Column store: clearing pass, read on accept, write on update in column mode
   always_ff @(posedge clock) begin
      if (cmd.clear) mem[clr_ff] <= '0;
      else if (cmd.update && column_mode_ff)
         mem[caddr] <= {lraw, end_mat ? SumWidth'(0) : sum_new};
      if (cmd.accept) rd_ff <= mem[caddr];
   end

   // Latch item, run divider, load output
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_ff   <= req_payload.sample;
         seg_ff <= req_payload.seg_length;
      end
      if (cmd.update) begin
         quo_ff  <= mag;
         rem_ff  <= '0;
         dlen_ff <= len;
         neg_ff  <= sum_new[SumWidth-1];
         zero_ff <= (len == '0);
         last_ff <= column_mode_ff ? end_row : end_mat;
         idx_ff  <= column_mode_ff ? IndexWidth'(caddr) : row_pos_ff;
      end else if (cmd.div_step) begin
         rem_ff <= qbit ? XW'(trial - (XW+1)'(dlen_ff)) : XW'(trial);
         quo_ff <= {quo_ff[SumWidth-2:0], qbit};
      end
      if (cmd.load_out) begin
         rsp_ff.mean        <= zero_ff ? '0 : $signed(neg_ff ? -qlow : qlow);
         rsp_ff.out_index   <= idx_ff;
         rsp_ff.zero_length <= zero_ff;
         rsp_ff.last        <= last_ff;
      end
   end

endmodule

[tb/tb.sv]
module tb;
   import mrcm_pkg::*;

   localparam int MaxCols   = 1024;
   localparam int MaxRows   = 4096;
   localparam int IdleLimit = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   masked_row_column_mean DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow copy of the block's registers and accumulators
   logic        mode_cols;
   logic        lengths_on;
   logic [12:0] rows_reg;
   logic [10:0] cols_reg;
   longint      col_acc [MaxCols];
   logic [12:0] col_len [MaxCols];
   longint      row_acc;
   int unsigned row_pos;
   int unsigned col_pos;

   rsp_payload_type pending_means[$];
   int errors = 0;
   int beats_sent = 0;
   int means_seen = 0;
   int zero_seen = 0;
   bit quiet = 1'b0;

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int unsigned count_len(input int unsigned len, input int unsigned ext);
      if (!lengths_on) return ext;
      return (len > ext) ? ext : len;
   endfunction

   // Queue the mean, if any, that one accepted beat closes
   function automatic void predict_mean(input logic signed [31:0] smp, input logic [12:0] seg);
      int unsigned rows, cols, len, c;
      bit end_row, end_mat, emit;
      longint sum, quot;
      int unsigned idx;
      rsp_payload_type m;
      rows = clamp_size(rows_reg, MaxRows);
      cols = clamp_size(cols_reg, MaxCols);
      end_row = (col_pos + 1 >= cols);
      end_mat = (row_pos + 1 >= rows);
      emit = 1'b0;
      if (mode_cols) begin
         c = (col_pos < MaxCols) ? col_pos : MaxCols - 1;
         if (row_pos == 0) begin
            col_len[c] = seg;
            col_acc[c] = 0;
         end
         len = count_len(col_len[c], rows);
         if (row_pos < len) col_acc[c] += longint'(smp);
         if (end_mat) begin
            emit = 1'b1;
            sum = col_acc[c];
            idx = c;
            m.last = end_row;
            col_acc[c] = 0;
         end
      end else begin
         len = count_len(seg, cols);
         if (col_pos == 0) row_acc = 0;
         if (col_pos < len) row_acc += longint'(smp);
         if (end_row) begin
            emit = 1'b1;
            sum = row_acc;
            idx = row_pos;
            m.last = end_mat;
            row_acc = 0;
         end
      end
      if (emit) begin
         quot = (len != 0) ? sum / longint'(len) : 0;
         m.mean = quot[31:0];
         m.out_index = idx[11:0];
         m.zero_length = (len == 0);
         pending_means = {pending_means, m};
      end
      if (end_row) begin
         col_pos = 0;
         row_pos = end_mat ? 0 : (row_pos + 1) & 12'hFFF;
      end else begin
         col_pos = (col_pos + 1) & 10'h3FF;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive one beat and hold it until taken
   task automatic send_beat(input logic signed [31:0] smp, input logic [12:0] seg);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.sample <= smp;
      req_payload.seg_length <= seg;
      do @(posedge clock); while (!req_ready);
      predict_mean(smp, seg);
      beats_sent++;
   endtask

   // Drive one register write; the caller drops csr_valid after the last one
   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CsrDataWidth-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COLUMN_MODE: mode_cols = value[0];
         CSR_USE_LENGTHS: lengths_on = value[0];
         CSR_NUM_ROWS:    rows_reg = value[12:0];
         CSR_NUM_COLS:    cols_reg = value[10:0];
         default: ;
      endcase
   endtask

   // Hold the sender until every mean is back and the divider has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_shape(input bit cm, input bit lo, input int unsigned r,
                            input int unsigned c);
      drain();
      write_reg(CSR_COLUMN_MODE, cm);
      write_reg(CSR_USE_LENGTHS, lo);
      write_reg(CSR_NUM_ROWS, r);
      write_reg(CSR_NUM_COLS, c);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'sh8000_0000;
      if (r == 1) return 32'sh7FFF_FFFF;
      if (r == 2) return $signed($urandom_range(0, 255)) - 128;
      return $urandom;
   endfunction

   function automatic logic [12:0] rand_len(input int unsigned ext);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 13'd0;
      if (r == 1) return 13'd4096;
      if (r == 2) return 13'($urandom_range(0, 4096));
      return 13'($urandom_range(0, ext + 1));
   endfunction

   // Send whole matrices so every phase ends with the positions back at zero
   task automatic send_matrix(input int unsigned rows, input int unsigned cols);
      logic [12:0] lens [MaxCols];
      logic [12:0] rl;
      for (int c = 0; c < cols; c++) lens[c] = rand_len(rows);
      for (int r = 0; r < rows; r++) begin
         rl = rand_len(cols);
         for (int c = 0; c < cols; c++)
            send_beat(rand_sample(), mode_cols ? lens[c] : rl);
      end
   endtask

   // Defaults after reset: each beat is a one-element row
   task automatic test_reset_defaults();
      send_beat(32'sh7FFF_FFFF, 13'd0);
      send_beat(32'sh8000_0000, 13'd4096);
      send_beat(32'sh0000_0000, 13'h1555);
      send_beat(-32'sd1, 13'h0AAA);
   endtask

   // Row lengths: each beat decides its own counting, last beat gives the divisor
   task automatic test_row_lengths();
      set_shape(1'b0, 1'b1, 4, 4);
      send_beat(32'sh7FFF_FFFF, 13'd4); send_beat(32'sh7FFF_FFFF, 13'd4);
      send_beat(32'sh7FFF_FFFF, 13'd4); send_beat(32'sh7FFF_FFFF, 13'd3);
      send_beat(-32'sd7, 13'd0); send_beat(32'sd5, 13'd1);
      send_beat(32'sd9, 13'd0); send_beat(32'sd2, 13'd0);
      send_beat(32'sh8000_0000, 13'd4096); send_beat(32'sh8000_0000, 13'd5);
      send_beat(32'sd3, 13'd2); send_beat(-32'sd3, 13'd4096);
      send_beat(-32'sd7, 13'd2); send_beat(32'sd0, 13'd2);
      send_beat(32'sd1, 13'd2); send_beat(32'sd1, 13'd2);
   endtask

   // Column lengths latched on row 0, including zero and oversize
   task automatic test_column_lengths();
      set_shape(1'b1, 1'b1, 3, 3);
      send_beat(-32'sd5, 13'd0); send_beat(32'sd10, 13'd2); send_beat(-32'sd8, 13'd4096);
      send_beat(32'sd1, 13'd3); send_beat(32'sd3, 13'd0); send_beat(-32'sd1, 13'd0);
      send_beat(32'sd1, 13'd1); send_beat(32'sd3, 13'd7); send_beat(-32'sd2, 13'd1);
   endtask

   // Zero sizes acting as one, then a long row and a tall column
   task automatic test_size_extremes();
      set_shape(1'b1, 1'b0, 0, 0);
      send_matrix(1, 1);
      set_shape(1'b0, 1'b1, 0, 0);
      send_matrix(1, 1);
      set_shape(1'b0, 1'b1, 1, 24);
      send_matrix(1, 24);
      set_shape(1'b1, 1'b0, 24, 1);
      send_matrix(24, 1);
   endtask

   // Random shapes and modes, small matrices, back-to-back stretches mixed in
   task automatic test_random();
      int unsigned r, c, target;
      target = beats_sent + 320;
      while (beats_sent < target) begin
         r = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         c = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         set_shape(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r, c);
         quiet = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) send_matrix(clamp_size(r, MaxRows),
                                                   clamp_size(c, MaxCols));
         quiet = 1'b0;
      end
   endtask

   // Receiver: mostly ready, short and occasional long stalls
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each mean with the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_means.size() == 0) begin
            $display("%0t: unexpected mean %h", $time, rsp_payload);
            errors++;
         end else begin
            want = pending_means.pop_front();
            means_seen++;
            if (want.zero_length) zero_seen++;
            if (rsp_payload.mean !== want.mean) begin
               $display("%0t: mean exp %h got %h", $time, want.mean, rsp_payload.mean);
               errors++;
            end
            if (rsp_payload.out_index !== want.out_index) begin
               $display("%0t: out_index exp %0d got %0d", $time, want.out_index,
                        rsp_payload.out_index);
               errors++;
            end
            if (rsp_payload.zero_length !== want.zero_length) begin
               $display("%0t: zero_length exp %b got %b", $time, want.zero_length,
                        rsp_payload.zero_length);
               errors++;
            end
            if (rsp_payload.last !== want.last) begin
               $display("%0t: last exp %b got %b", $time, want.last, rsp_payload.last);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no beat moving on any channel
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("masked_row_column_mean verification failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      mode_cols = 1'b0;
      lengths_on = 1'b0;
      rows_reg = 13'd1;
      cols_reg = 11'd1;
      row_acc = 0;
      row_pos = 0;
      col_pos = 0;
      for (int i = 0; i < MaxCols; i++) begin
         col_acc[i] = 0;
         col_len[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_row_lengths();
      test_column_lengths();
      test_size_extremes();
      test_random();
      drain();
      repeat (60) @(posedge clock);
      $display("Sent %0d beats, checked %0d means (%0d zero-length).",
               beats_sent, means_seen, zero_seen);
      $display("Covered row and column modes, lengths on and off, zero and long sizes.");
      if (errors == 0 && pending_means.size() == 0)
         $display("masked_row_column_mean verification clean");
      else
         $display("masked_row_column_mean verification failed");
      $finish;
   end

endmodule

[sim.f]
design/mrcm_pkg.sv
design/mrcm_ctrl.sv
design/mrcm_dpath.sv
design/masked_row_column_mean.sv
tb/tb.sv
